### sv/cdu_pkg.sv
// package for the calendar date to unix time converter
// item and stage types, conversion constants and the month offset table
// no dependencies
`default_nettype none

package cdu_pkg;

  localparam int EPOCH_YEAR  = 1970;
  localparam int YEAR_DAYS   = 365;
  localparam int LEAP_BIAS   = 477;
  localparam int CENTURY     = 100;
  localparam int CENTURY_END = 99;
  localparam int RECIP_100   = 1311;
  localparam int RECIP_SHIFT = 17;
  localparam int HOUR_SEC    = 3600;
  localparam int MIN_SEC     = 60;
  localparam int DAY_SEC     = 86400;
  localparam logic [3:0] MARCH = 4'd3;
  localparam logic KIND_DAY_OF_YEAR = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [11:0] year;
    logic [3:0]  month;
    logic [8:0]  day_number;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
  } item_t;

  typedef struct packed {
    logic [11:0]        year;
    logic signed [10:0] doy;
    logic signed [10:0] leap_cnt;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [9:0]         millisecond;
  } mid_t;

  typedef struct packed {
    logic [34:0] unix_sec;
    logic [44:0] unix_msec;
    logic [8:0]  day_of_year;
  } res_t;

  // days before the first of the month in a common year, january based with january as day 0
  function automatic logic signed [10:0] month_offset(input logic [3:0] month);
    logic signed [10:0] off;
    case (month)
      4'd0:    off = -11'sd31;
      4'd1:    off = 11'sd0;
      4'd2:    off = 11'sd31;
      4'd3:    off = 11'sd59;
      4'd4:    off = 11'sd90;
      4'd5:    off = 11'sd120;
      4'd6:    off = 11'sd151;
      4'd7:    off = 11'sd181;
      4'd8:    off = 11'sd212;
      4'd9:    off = 11'sd243;
      4'd10:   off = 11'sd273;
      4'd11:   off = 11'sd304;
      4'd12:   off = 11'sd334;
      4'd13:   off = 11'sd365;
      4'd14:   off = 11'sd396;
      4'd15:   off = 11'sd426;
      default: off = 11'sd0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

### sv/cdu_doy.sv
// day of year and leap day count, two pipeline stages
// depends on cdu_pkg
`default_nettype none

module cdu_doy (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cdu_pkg::item_t in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output cdu_pkg::mid_t out_item
);
  import cdu_pkg::*;

  logic signed [12:0] w;
  logic [22:0]        prod;
  logic [22:0]        qs;
  logic signed [6:0]  q100;

  logic               v1;
  logic               kind1;
  logic [11:0]        year1;
  logic signed [12:0] w1;
  logic signed [6:0]  q1001;
  logic signed [10:0] offset1;
  logic               late1;
  logic [8:0]         dnum1;
  logic [4:0]         hour1;
  logic [5:0]         minute1;
  logic [5:0]         second1;
  logic [9:0]         ms1;

  logic               en1;
  logic               en2;
  logic signed [12:0] hund;
  logic signed [12:0] r100;
  logic               leap;
  logic signed [12:0] q4;
  logic signed [12:0] lc;
  logic signed [10:0] dn;
  logic signed [10:0] doy;

  assign en2      = !out_valid || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // w = year - 1, quotient by 100 through a reciprocal, valid for w >= 0
  assign w    = $signed({1'b0, in_item.year}) - 13'sd1;
  assign prod = 23'(w[11:0]) * 23'(RECIP_100);
  assign qs   = prod >> RECIP_SHIFT;
  assign q100 = w[12] ? -7'sd1 : $signed({1'b0, qs[5:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      kind1   <= in_item.kind;
      year1   <= in_item.year;
      w1      <= w;
      q1001   <= q100;
      offset1 <= month_offset(in_item.month);
      late1   <= in_item.month >= MARCH;
      dnum1   <= in_item.day_number;
      hour1   <= in_item.hour;
      minute1 <= in_item.minute;
      second1 <= in_item.second;
      ms1     <= in_item.millisecond;
    end
  end

  assign hund = 13'(CENTURY) * 13'(q1001);
  assign r100 = w1 - hund;
  // year zero is a leap year and is the only case with w negative
  assign leap = w1[12] ? 1'b1 :
                (year1[1:0] == 2'b00) &&
                ((r100 != 13'(CENTURY_END)) || (q1001[1:0] == 2'b11));
  assign q4   = w1 >>> 2;
  assign lc   = q4 - 13'(q1001) + 13'(q1001 >>> 2) - 13'(LEAP_BIAS);
  assign dn   = $signed({2'b00, dnum1});
  assign doy  = (kind1 == KIND_DAY_OF_YEAR) ? dn :
                dn + offset1 + $signed({10'd0, leap && late1});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      out_item.year        <= year1;
      out_item.doy         <= doy;
      out_item.leap_cnt    <= lc[10:0];
      out_item.hour        <= hour1;
      out_item.minute      <= minute1;
      out_item.second      <= second1;
      out_item.millisecond <= ms1;
    end
  end

endmodule

`default_nettype wire

### sv/cdu_secs.sv
// day count, seconds and milliseconds since the epoch, three pipeline stages
// depends on cdu_pkg
`default_nettype none

module cdu_secs (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cdu_pkg::mid_t in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output cdu_pkg::res_t out_item
);
  import cdu_pkg::*;

  logic               en3;
  logic               en4;
  logic               en5;

  logic signed [12:0] ys;
  logic signed [21:0] days;
  logic [16:0]        tod;

  logic               v3;
  logic signed [21:0] days3;
  logic [16:0]        tod3;
  logic [8:0]         doy3;
  logic [9:0]         ms3;

  logic signed [38:0] secs;
  logic               v4;
  logic signed [38:0] secs4;
  logic [8:0]         doy4;
  logic [9:0]         ms4;

  logic signed [48:0] sx;
  logic signed [48:0] msec;

  assign en5      = !out_valid || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign in_ready = en3;

  assign ys   = $signed({1'b0, in_item.year}) - 13'(EPOCH_YEAR);
  assign days = 22'(ys) * 22'(YEAR_DAYS) + 22'($signed(in_item.leap_cnt))
              + 22'($signed(in_item.doy)) - 22'sd1;
  assign tod  = 17'(in_item.hour) * 17'(HOUR_SEC) + 17'(in_item.minute) * 17'(MIN_SEC)
              + 17'(in_item.second);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && in_valid) begin
      days3 <= days;
      tod3  <= tod;
      doy3  <= in_item.doy[8:0];
      ms3   <= in_item.millisecond;
    end
  end

  assign secs = 39'(days3) * 39'(DAY_SEC) + $signed({22'd0, tod3});

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      secs4 <= secs;
      doy4  <= doy3;
      ms4   <= ms3;
    end
  end

  // times 1000 as 1024 - 16 - 8
  assign sx   = 49'(secs4);
  assign msec = (sx <<< 10) - (sx <<< 4) - (sx <<< 3) + $signed({39'd0, ms4});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en5) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      out_item.unix_sec    <= secs4[34:0];
      out_item.unix_msec   <= msec[44:0];
      out_item.day_of_year <= doy4;
    end
  end

endmodule

`default_nettype wire

### sv/calendar_date_to_unix_time.sv
// top level of the calendar date to unix time converter
// depends on cdu_pkg, cdu_doy and cdu_secs
//
// Converts one UTC time stamp per item into seconds and milliseconds since
// 1970-01-01 00:00:00 and the day of year used. The date is year, month and
// day of month (tuser 0) or year and day of year (tuser 1); fields are taken
// as given with no range checks, and results wrap at their widths. The block
// is a five stage pipeline: it takes one item every cycle while the output
// is not stalled. Each stage holds its item until the next stage frees, so
// stalls lose and repeat nothing and empty stages fill while the output
// waits.
`default_nettype none

module calendar_date_to_unix_time (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // year, month, day_number, hour, minute, second, millisecond
  input  logic [55:0] s_axis_tdata,
  // kind
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // unix_sec, unix_msec, day_of_year
  output logic [95:0] m_axis_tdata
);
  import cdu_pkg::*;

  item_t in_item;
  mid_t  mid_item;
  res_t  res_item;
  logic  doy_ready;
  logic  mid_valid;
  logic  mid_ready;

  assign in_item.kind        = s_axis_tuser[0];
  assign in_item.year        = s_axis_tdata[11:0];
  assign in_item.month       = s_axis_tdata[15:12];
  assign in_item.day_number  = s_axis_tdata[24:16];
  assign in_item.hour        = s_axis_tdata[29:25];
  assign in_item.minute      = s_axis_tdata[35:30];
  assign in_item.second      = s_axis_tdata[41:36];
  assign in_item.millisecond = s_axis_tdata[51:42];

  assign s_axis_tready = doy_ready && !rst;

  cdu_doy u_doy (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (doy_ready),
    .in_item   (in_item),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_item  (mid_item)
  );

  cdu_secs u_secs (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_item   (mid_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (res_item)
  );

  assign m_axis_tdata = {7'd0, res_item.day_of_year, res_item.unix_msec, res_item.unix_sec};

  // an open output frees every stage, so the input must be open too
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is open");

  // with the output held open, an accepted item reaches the output valid
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tready && $past(m_axis_tready, 1) && $past(m_axis_tready, 2) &&
     $past(m_axis_tready, 3) && $past(m_axis_tready, 4) &&
     $past(m_axis_tready, 5) &&
     !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3) &&
     !$past(rst, 4) && !$past(rst, 5))
    |-> (m_axis_tvalid == $past(s_axis_tvalid && s_axis_tready, 5)))
    else $error("pipeline latency mismatch");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output item present right after reset");

endmodule

`default_nettype wire

### verif/tb_calendar_date_to_unix_time.sv
// testbench for calendar_date_to_unix_time: directed and random time stamps
// checked against an in-bench conversion, with random stalls on both streams
// depends on cdu_pkg and the calendar_date_to_unix_time rtl
`default_nettype none

module tb_calendar_date_to_unix_time;
  import cdu_pkg::*;

  localparam logic KIND_MONTH_DAY = 1'b0;
  localparam int   DRAIN_CYCLES   = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // year, month, day_number, hour, minute, second, millisecond
  logic [55:0] s_axis_tdata = '0;
  // kind
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // unix_sec, unix_msec, day_of_year
  logic [95:0] m_axis_tdata;

  res_t pending_times[$];
  int   mismatches = 0;
  int   sink_wait = 0;
  int   sink_draw;
  bit   src_steady = 1'b0;
  bit   sink_steady = 1'b0;

  calendar_date_to_unix_time u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) < 0) q = q - 1;
    return q;
  endfunction

  // julian day number less its constant offset
  function automatic longint julian_core(longint yr, longint mo, longint dy);
    longint a, y, m;
    a = (mo <= 2) ? 1 : 0;
    y = yr + 4800 - a;
    m = mo + 12 * a - 3;
    return dy + (153 * m + 2) / 5 + 365 * y + y / 4 - y / 100 + y / 400;
  endfunction

  function automatic res_t convert_stamp(item_t st);
    res_t   r;
    longint yr, doy, sy, a4, a100, a400, leap, days, hr, mi, sc, ms, secs, msecs;
    yr = st.year;
    hr = st.hour;
    mi = st.minute;
    sc = st.second;
    ms = st.millisecond;
    if (st.kind == KIND_DAY_OF_YEAR) doy = st.day_number;
    else doy = julian_core(yr, st.month, st.day_number) - julian_core(yr, 1, 1) + 1;
    sy   = yr - 1900;
    a4   = floor_quot(sy, 4) + 475 - ((sy % 4 == 0) ? 1 : 0);
    a100 = floor_quot(a4, 25);
    a400 = floor_quot(a100, 4);
    leap = (a4 - 492) - (a100 - 19) + (a400 - 4);
    days = 365 * (sy - 70) + leap + (doy - 1);
    secs = 60 * (60 * (24 * days + hr) + mi) + sc;
    msecs = 1000 * secs + ms;
    r.unix_sec    = secs[34:0];
    r.unix_msec   = msecs[44:0];
    r.day_of_year = doy[8:0];
    return r;
  endfunction

  function automatic item_t make_stamp(logic kind, int year, int month, int dnum,
                                       int hour, int minute, int second, int msec);
    item_t st;
    st.kind        = kind;
    st.year        = year[11:0];
    st.month       = month[3:0];
    st.day_number  = dnum[8:0];
    st.hour        = hour[4:0];
    st.minute      = minute[5:0];
    st.second      = second[5:0];
    st.millisecond = msec[9:0];
    return st;
  endfunction

  function automatic item_t random_stamp();
    item_t st;
    if ($urandom_range(0, 99) < 85) begin
      st.kind        = 1'($urandom_range(0, 1));
      st.year        = 12'($urandom_range(1600, 2399));
      st.month       = 4'($urandom_range(1, 12));
      st.day_number  = (st.kind == KIND_DAY_OF_YEAR) ? 9'($urandom_range(1, 366))
                                                     : 9'($urandom_range(1, 31));
      st.hour        = 5'($urandom_range(0, 23));
      st.minute      = 6'($urandom_range(0, 59));
      st.second      = 6'($urandom_range(0, 60));
      st.millisecond = 10'($urandom_range(0, 999));
    end else begin
      st = 53'({$urandom(), $urandom()});
    end
    return st;
  endfunction

  // the valid is only lowered when a gap follows
  task automatic send_item(item_t st);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 56'({$urandom(), $urandom()});
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= st.kind;
    s_axis_tdata  <= {4'b0, st.millisecond, st.second, st.minute, st.hour,
                      st.day_number, st.month, st.year};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_for_results();
    while (pending_times.size() != 0) @(posedge clk);
  endtask

  // input monitor: every accepted item queues its conversion
  always @(posedge clk) begin
    item_t st;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      st.kind        = s_axis_tuser[0];
      st.year        = s_axis_tdata[11:0];
      st.month       = s_axis_tdata[15:12];
      st.day_number  = s_axis_tdata[24:16];
      st.hour        = s_axis_tdata[29:25];
      st.minute      = s_axis_tdata[35:30];
      st.second      = s_axis_tdata[41:36];
      st.millisecond = s_axis_tdata[51:42];
      pending_times.push_back(convert_stamp(st));
    end
  end

  // output checker
  always @(posedge clk) begin
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_times.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_times.pop_front();
        if (m_axis_tdata[34:0] !== want.unix_sec) begin
          $display("%0t: unix_sec expected %h actual %h", $time, want.unix_sec,
                   m_axis_tdata[34:0]);
          mismatches++;
        end
        if (m_axis_tdata[79:35] !== want.unix_msec) begin
          $display("%0t: unix_msec expected %h actual %h", $time, want.unix_msec,
                   m_axis_tdata[79:35]);
          mismatches++;
        end
        if (m_axis_tdata[88:80] !== want.day_of_year) begin
          $display("%0t: day_of_year expected %0d actual %0d", $time,
                   want.day_of_year, m_axis_tdata[88:80]);
          mismatches++;
        end
      end
    end
  end

  // output stall per item
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_wait     <= 0;
    end else if (sink_wait != 0) begin
      sink_wait     <= sink_wait - 1;
      m_axis_tready <= (sink_wait == 1);
    end else if (m_axis_tvalid && m_axis_tready) begin
      sink_draw      = sink_steady ? 0 : $urandom_range(0, 13);
      sink_wait     <= sink_draw;
      m_axis_tready <= (sink_draw == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic test_extremes();
    send_item(make_stamp(KIND_MONTH_DAY, 1970, 1, 1, 0, 0, 0, 0));
    send_item(make_stamp(KIND_MONTH_DAY, 1600, 1, 1, 0, 0, 0, 0));
    send_item(make_stamp(KIND_MONTH_DAY, 2399, 12, 31, 23, 59, 60, 999));
    send_item(make_stamp(KIND_DAY_OF_YEAR, 2000, 9, 366, 23, 59, 59, 999));
    send_item(make_stamp(KIND_DAY_OF_YEAR, 1969, 1, 1, 0, 0, 0, 1));
  endtask

  task automatic test_leap_rules();
    send_item(make_stamp(KIND_MONTH_DAY, 2000, 2, 29, 12, 0, 0, 0));
    send_item(make_stamp(KIND_MONTH_DAY, 1900, 3, 1, 0, 0, 0, 0));
    send_item(make_stamp(KIND_MONTH_DAY, 2100, 3, 1, 0, 0, 0, 0));
    send_item(make_stamp(KIND_MONTH_DAY, 1600, 12, 31, 0, 0, 0, 0));
    send_item(make_stamp(KIND_MONTH_DAY, 2004, 12, 31, 6, 30, 15, 500));
    send_item(make_stamp(KIND_MONTH_DAY, 1968, 2, 29, 0, 0, 0, 0));
  endtask

  task automatic test_unchecked_fields();
    send_item(make_stamp(KIND_MONTH_DAY, 2001, 0, 15, 0, 0, 0, 0));
    send_item(make_stamp(KIND_MONTH_DAY, 2001, 13, 1, 0, 0, 0, 0));
    send_item(make_stamp(KIND_MONTH_DAY, 2000, 15, 511, 0, 0, 0, 0));
    send_item(make_stamp(KIND_MONTH_DAY, 1999, 2, 0, 0, 0, 0, 0));
    send_item(make_stamp(KIND_DAY_OF_YEAR, 1985, 15, 0, 0, 0, 0, 0));
    send_item(make_stamp(KIND_DAY_OF_YEAR, 2020, 0, 511, 31, 63, 63, 1023));
    send_item(make_stamp(KIND_MONTH_DAY, 0, 1, 1, 0, 0, 0, 0));
    send_item(make_stamp(KIND_MONTH_DAY, 4095, 12, 31, 31, 63, 63, 1023));
    send_item(make_stamp(KIND_DAY_OF_YEAR, 4095, 15, 511, 31, 63, 63, 1023));
    send_item(make_stamp(KIND_MONTH_DAY, 2048, 7, 4, 31, 63, 63, 1023));
  endtask

  task automatic test_random_stamps(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        src_steady  = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
      end
      send_item(random_stamp());
    end
  endtask

  // sender holds off until the pipeline is empty, then restarts back to back
  task automatic test_drain_pause();
    src_steady = 1'b1;
    for (int i = 0; i < 20; i++) send_item(random_stamp());
    s_axis_tvalid <= 1'b0;
    wait_for_results();
    for (int i = 0; i < 20; i++) send_item(random_stamp());
    src_steady = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_leap_rules();
    test_unchecked_fields();
    test_random_stamps(180);
    test_drain_pause();
    test_random_stamps(180);
    s_axis_tvalid <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
sv/cdu_pkg.sv
sv/cdu_doy.sv
sv/cdu_secs.sv
sv/calendar_date_to_unix_time.sv
verif/tb_calendar_date_to_unix_time.sv
